// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the scanline source mapper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge, skipped while reset is high.
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_RST(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== hdl/smap_pkg.sv =====
// Types and constants shared by the scanline source mapper modules.
`default_nettype none

package smap_pkg;

   // Field widths.
   localparam int CFG_LINE_W = 11;
   localparam int CFG_SLOT_W = 5;
   localparam int CFG_REP_W  = 4;
   localparam int IDX_W      = 10;
   localparam int KIND_W     = 2;

   // Port widths.
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 11;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 16;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_ACTIVE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PERIOD   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BUFFERED = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SLOTS    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_REPEAT   = 3'd4;

   // Register reset values.
   localparam logic [CFG_LINE_W-1:0] RST_ACTIVE   = 11'd600;
   localparam logic [CFG_LINE_W-1:0] RST_PERIOD   = 11'd628;
   localparam logic [CFG_LINE_W-1:0] RST_BUFFERED = 11'd600;
   localparam logic [CFG_SLOT_W-1:0] RST_SLOTS    = 5'd2;
   localparam logic [CFG_REP_W-1:0]  RST_REPEAT   = 4'd1;

   // Line source kinds.
   localparam logic [KIND_W-1:0] KIND_BUFFER = 2'd0;
   localparam logic [KIND_W-1:0] KIND_INTERP = 2'd1;
   localparam logic [KIND_W-1:0] KIND_BLANK  = 2'd2;

   // Effective (clamped) configuration.
   typedef struct packed {
      logic [CFG_LINE_W-1:0] act_lines;
      logic [CFG_LINE_W-1:0] per_lines;
      logic [CFG_LINE_W-1:0] buf_lines;
      logic [CFG_SLOT_W-1:0] slots;
      logic [CFG_REP_W-1:0]  reps;
   } smap_cfg_type;

endpackage

`default_nettype wire

// ===== hdl/smap_cfg.sv =====
// Configuration registers of the scanline source mapper, with range clamping.
`default_nettype none

module smap_cfg #(
   parameter int MAX_LINES  = 1024,
   parameter int MAX_REPEAT = 8,
   parameter int MAX_SLOTS  = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [smap_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [smap_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output smap_pkg::smap_cfg_type                cfg
);
   import smap_pkg::*;

   logic [CFG_LINE_W-1:0] active_ff, period_ff, buffered_ff;
   logic [CFG_SLOT_W-1:0] slots_ff;
   logic [CFG_REP_W-1:0]  repeat_ff;

   logic [CFG_LINE_W-1:0] act_eff;
   logic [CFG_LINE_W-1:0] per_cap;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= RST_ACTIVE;
         period_ff   <= RST_PERIOD;
         buffered_ff <= RST_BUFFERED;
         slots_ff    <= RST_SLOTS;
         repeat_ff   <= RST_REPEAT;
      end else if (csr_we) begin
         case (csr_index)
            REG_ACTIVE:   active_ff   <= csr_wdata[CFG_LINE_W-1:0];
            REG_PERIOD:   period_ff   <= csr_wdata[CFG_LINE_W-1:0];
            REG_BUFFERED: buffered_ff <= csr_wdata[CFG_LINE_W-1:0];
            REG_SLOTS:    slots_ff    <= csr_wdata[CFG_SLOT_W-1:0];
            REG_REPEAT:   repeat_ff   <= csr_wdata[CFG_REP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      // clamp active to 1..MAX_LINES
      if (active_ff == '0) begin
         act_eff = CFG_LINE_W'(1);
      end else if (int'(active_ff) > MAX_LINES) begin
         act_eff = CFG_LINE_W'(MAX_LINES);
      end else begin
         act_eff = active_ff;
      end

      // period capped at MAX_LINES, never below active
      if (int'(period_ff) > MAX_LINES) begin
         per_cap = CFG_LINE_W'(MAX_LINES);
      end else begin
         per_cap = period_ff;
      end

      cfg.act_lines = act_eff;
      cfg.per_lines = (per_cap < act_eff) ? act_eff : per_cap;
      cfg.buf_lines = buffered_ff;

      if (slots_ff < CFG_SLOT_W'(2)) begin
         cfg.slots = CFG_SLOT_W'(2);
      end else if (int'(slots_ff) > MAX_SLOTS) begin
         cfg.slots = CFG_SLOT_W'(MAX_SLOTS);
      end else begin
         cfg.slots = slots_ff;
      end

      if (repeat_ff == '0) begin
         cfg.reps = CFG_REP_W'(1);
      end else if (int'(repeat_ff) > MAX_REPEAT) begin
         cfg.reps = CFG_REP_W'(MAX_REPEAT);
      end else begin
         cfg.reps = repeat_ff;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/smap_div.sv =====
// Bit-serial restoring divider: one quotient bit per clock.
`default_nettype none

module smap_div #(
   parameter int W = 11
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [W-1:0] dividend,
   input  wire logic [W-1:0] divisor,
   output logic              busy,
   output logic              done,
   output logic [W-1:0]      quotient,
   output logic [W-1:0]      remainder
);
   localparam int CNT_W = $clog2(W + 1);

   logic [W-1:0]     quo_ff, quo_in;
   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     dvs_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [W:0] shifted;
   logic [W:0] diff;
   logic       fits;

   always_comb begin
      // shift in the next dividend bit and try the subtract
      shifted = {rem_ff, quo_ff[W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      fits    = (shifted >= {1'b0, dvs_ff});

      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = CNT_W'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[W-2:0], fits};
         rem_in = fits ? diff[W-1:0] : shifted[W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== hdl/scanline_source_mapper.sv =====
// Top level of the scanline source mapper: row sequencing and source choice.
//
//   channel  direction  fields (low bit first)
//   req_     in         tdata: row_tick
//   rsp_     out        tdata: line_index; tuser: line_kind; tlast: frame_end
//   csr_     in         write: index 0 active, 1 period, 2 buffered, 3 slots, 4 repeat
//
// A row beat is accepted in the idle state, then the pick state puts the source
// choice in the output register. The first row of a frame that needs interpolation
// first runs the bit-serial divider (active / (active - buffered)), one quotient bit
// per cycle, before the choice is made. reset is synchronous and clears the
// sequencer, the line counters and the output valid. A stalled result holds
// in the output register while the next beat is taken and worked on; the
// choice then waits until the output register frees.
`default_nettype none

module scanline_source_mapper #(
   parameter int MAX_LINES  = 1024,
   parameter int MAX_REPEAT = 8,
   parameter int MAX_SLOTS  = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // row request: row_tick
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [smap_pkg::REQ_DATA_W-1:0]  req_tdata,
   // line source: line_index
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [smap_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // line_kind
   output logic [smap_pkg::KIND_W-1:0]           rsp_tuser,
   output logic                                  rsp_tlast,
   // configuration writes
   input  wire logic                             csr_we,
   input  wire logic [smap_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [smap_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import smap_pkg::*;

`include "assert_macros.svh"

   localparam int SLOT_W = $clog2(MAX_SLOTS);
   localparam int REP_W  = $clog2(MAX_REPEAT + 1);
   localparam int SCMP_W = ((SLOT_W > CFG_SLOT_W) ? SLOT_W : CFG_SLOT_W) + 1;
   localparam int RCMP_W = ((REP_W > CFG_REP_W) ? REP_W : CFG_REP_W) + 1;

   // Sequencer states.
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_PICK = 2'd2;

   smap_cfg_type cfg;

   logic [1:0]            state_ff, state_in;
   logic [IDX_W-1:0]      line_ff, line_in;       // logical line in frame
   logic [REP_W-1:0]      rep_ff, rep_in;         // display row within line
   logic [IDX_W-1:0]      bufl_ff, bufl_in;       // next buffered line
   logic [SLOT_W-1:0]     slot_ff, slot_in;       // next interpolated slot
   logic [IDX_W-1:0]      spares_ff, spares_in;
   logic [CFG_LINE_W-1:0] seg_ff, seg_in;
   logic [CFG_LINE_W-1:0] mod1_ff, mod1_in;       // line mod (seg + 1)
   logic [CFG_LINE_W-1:0] mod0_ff, mod0_in;       // line mod seg
   logic [KIND_W-1:0]     kind_ff, kind_in;
   logic [IDX_W-1:0]      cidx_ff, cidx_in;
   logic                  vld_ff, vld_in;
   logic [IDX_W-1:0]      oidx_ff, oidx_in;
   logic [KIND_W-1:0]     okind_ff, okind_in;
   logic                  olast_ff, olast_in;

   logic                  req_fire;
   logic                  frame_top;
   logic                  need_div;
   logic [CFG_LINE_W-1:0] div_den;
   logic                  div_start;
   logic                  div_busy;
   logic                  div_done;
   logic [CFG_LINE_W-1:0] div_quo;
   logic [CFG_LINE_W-1:0] div_rem;

   logic                  out_free;
   logic                  blank;
   logic                  interp_sp;
   logic                  interp_pl;
   logic [SLOT_W-1:0]     slot_k;
   logic [SLOT_W-1:0]     slot_k1;
   logic                  last_row;
   logic                  last_line;

   smap_cfg #(
      .MAX_LINES  (MAX_LINES),
      .MAX_REPEAT (MAX_REPEAT),
      .MAX_SLOTS  (MAX_SLOTS)
   ) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   smap_div #(
      .W (CFG_LINE_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (cfg.act_lines),
      .divisor   (div_den),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Take a row beat only when the sequencer is free; the output register
   // parts us from the result side.
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign frame_top  = (rep_ff == '0) && (line_ff == '0);
   assign need_div   = (cfg.buf_lines < cfg.act_lines);
   assign div_den    = cfg.act_lines - cfg.buf_lines;
   assign div_start  = req_fire && req_tdata[0] && frame_top && need_div;
   assign out_free   = !vld_ff || rsp_tready;

   always_comb begin
      // line classification for the logical line we sit on
      blank     = ({1'b0, line_ff} >= cfg.act_lines);
      interp_sp = (seg_ff != '0) && (spares_ff != '0) && (mod1_ff == '0);
      interp_pl = (seg_ff != '0) && (spares_ff == '0) && (mod0_ff == '0);

      // a slot at or past the slot count reads as slot zero
      slot_k  = (SCMP_W'(slot_ff) < SCMP_W'(cfg.slots)) ? slot_ff : '0;
      slot_k1 = ((SCMP_W'(slot_k) + SCMP_W'(1)) >= SCMP_W'(cfg.slots)) ? '0
                : SLOT_W'(slot_k + 1'b1);

      last_row  = ((RCMP_W'(rep_ff) + RCMP_W'(1)) >= RCMP_W'(cfg.reps));
      last_line = (({1'b0, line_ff} + CFG_LINE_W'(1)) >= cfg.per_lines);

      state_in  = state_ff;
      line_in   = line_ff;
      rep_in    = rep_ff;
      bufl_in   = bufl_ff;
      slot_in   = slot_ff;
      spares_in = spares_ff;
      seg_in    = seg_ff;
      mod1_in   = mod1_ff;
      mod0_in   = mod0_ff;
      kind_in   = kind_ff;
      cidx_in   = cidx_ff;
      vld_in    = vld_ff && !rsp_tready;
      oidx_in   = oidx_ff;
      okind_in  = okind_ff;
      olast_in  = olast_ff;

      case (state_ff)
         S_IDLE: begin
            // drop idle ticks; on a real tick set up the frame if at its top
            if (req_fire && req_tdata[0]) begin
               state_in = S_PICK;
               if (frame_top) begin
                  bufl_in = '0;
                  slot_in = '0;
                  if (need_div) begin
                     state_in = S_DIV;
                  end else begin
                     seg_in    = '0;
                     spares_in = '0;
                  end
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               seg_in    = div_quo;
               spares_in = div_rem[IDX_W-1:0];
               state_in  = S_PICK;
            end
         end
         S_PICK: begin
            if (out_free) begin
               // choose the source on the first row of a logical line, hold it after
               if (rep_ff == '0) begin
                  if (blank) begin
                     kind_in = KIND_BLANK;
                     cidx_in = '0;
                  end else if (interp_sp || interp_pl) begin
                     kind_in = KIND_INTERP;
                     cidx_in = IDX_W'(slot_k);
                     slot_in = slot_k1;
                     if (interp_sp) begin
                        spares_in = spares_ff - 1'b1;
                     end
                  end else begin
                     kind_in = KIND_BUFFER;
                     cidx_in = bufl_ff;
                     bufl_in = bufl_ff + 1'b1;
                  end
               end

               vld_in   = 1'b1;
               okind_in = kind_in;
               oidx_in  = cidx_in;
               olast_in = last_row && last_line;

               // advance row, then line; restart the modulo counters with the frame
               if (last_row) begin
                  rep_in = '0;
                  if (last_line) begin
                     line_in = '0;
                     mod1_in = '0;
                     mod0_in = '0;
                  end else begin
                     line_in = line_ff + 1'b1;
                     mod1_in = (mod1_ff == seg_ff) ? '0 : mod1_ff + 1'b1;
                     mod0_in = ((mod0_ff + 1'b1) == seg_ff) ? '0 : mod0_ff + 1'b1;
                  end
               end else begin
                  rep_in = rep_ff + 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         line_ff   <= '0;
         rep_ff    <= '0;
         bufl_ff   <= '0;
         slot_ff   <= '0;
         spares_ff <= '0;
         seg_ff    <= '0;
         mod1_ff   <= '0;
         mod0_ff   <= '0;
         kind_ff   <= KIND_BUFFER;
         cidx_ff   <= '0;
         vld_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         line_ff   <= line_in;
         rep_ff    <= rep_in;
         bufl_ff   <= bufl_in;
         slot_ff   <= slot_in;
         spares_ff <= spares_in;
         seg_ff    <= seg_in;
         mod1_ff   <= mod1_in;
         mod0_ff   <= mod0_in;
         kind_ff   <= kind_in;
         cidx_ff   <= cidx_in;
         vld_ff    <= vld_in;
      end
      oidx_ff  <= oidx_in;
      okind_ff <= okind_in;
      olast_ff <= olast_in;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - IDX_W){1'b0}}, oidx_ff};
   assign rsp_tuser  = okind_ff;
   assign rsp_tlast  = olast_ff;

   // a new result only ever comes out of the pick state
   `ASSERT_RST(a_vld_from_pick, clock, reset, $rose(vld_ff) |-> $past(state_ff == S_PICK), "stray result")
   // while waiting on the quotient the divider is running or just finished
   `ASSERT_RST(a_div_live, clock, reset, (state_ff == S_DIV) |-> (div_busy || div_done), "divider idle")
   // the line-mod-seg counter stays below the segment length
   `ASSERT_RST(a_mod_range, clock, reset, (seg_ff != '0) |-> (mod0_ff < seg_ff), "segment count range")
   // reset empties the output register
   `ASSERT_ALWAYS(a_rst_empty, clock, reset |=> !rsp_tvalid, "result valid after reset")

endmodule

`default_nettype wire
